[hw/rtl/itrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_pkg
// Types, constants and the alphabet check shared by the radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_W         = 32;
  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 5;
  localparam int DIGIT_W         = 4;
  localparam int NUM_CHARS       = 16;
  localparam int MAX_DIGITS      = 32;
  localparam int CNT_W           = 6;
  localparam int BITS_PER_STEP   = 8;
  localparam int STEP_W          = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(VALUE_W / BITS_PER_STEP - 1);
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] itrd_alpha_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } itrd_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sign;
    logic emit;
  } itrd_cmd_t;

  typedef struct packed {
    logic ok;
    logic div_done;
    logic neg;
    logic out_free;
    logic last_digit;
  } itrd_stat_t;

  // No sign character and no repeated character among the used entries.
  function automatic logic alphabet_chars_ok(logic [LEN_W-1:0] len, itrd_alpha_t alpha);
    logic ok;
    ok = 1'b1;
    for (int a = 0; a < NUM_CHARS; a++) begin
      if (LEN_W'(a) < len) begin
        if (alpha[a] == CHAR_PLUS || alpha[a] == CHAR_MINUS) ok = 1'b0;
        for (int b = a + 1; b < NUM_CHARS; b++) begin
          if (LEN_W'(b) < len && alpha[a] == alpha[b]) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

[hw/rtl/itrd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_if
// Valid/ready channels of the radix digit converter: value in, characters out.
// ----------------------------------------------------------------------------
interface itrd_in_if;
  import itrd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itrd_out_if;
  import itrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[hw/rtl/integer_to_radix_digits_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a signed 32-bit value to its text in a configured radix 2..16.
// ----------------------------------------------------------------------------
// Usage:
//   Write radix_length (index 0) and the packed digit alphabet (indices 1, 2)
//   on the cfg_ port while the unit is idle. Each item on in_if is one value;
//   out_if returns its characters, most significant first, a leading '-' for
//   negative values, with last set on the final character. If the alphabet is
//   not usable (radix below 2 or above MAX_RADIX, a '+' or '-' among the used
//   characters, or a repeated character) the item yields no characters.
// Flow:
//   accept, then the alphabet check; the divider produces one digit per pass
//   over the value (8 quotient bits a cycle), then one character a cycle,
//   while out_if is ready, leaves through the output register, after the
//   sign character for negative values. A rejected alphabet ends the item
//   after the check. One item is in work at a time; the
//   next item is taken while the final character still waits in the output
//   register.
// Reset clears the configuration to zero and drops any item in work.
// A stall on out_if holds the current character and pauses emission.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit #(
  parameter int MAX_RADIX = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  itrd_in_if.sink                         in_if,
  itrd_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import itrd_pkg::*;

  itrd_cmd_t  cmd;
  itrd_stat_t stat;
  logic       in_ready;

  assign in_if.ready = in_ready;

  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itrd_dp #(
    .MAX_RADIX (MAX_RADIX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_value      (in_if.value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_character (out_if.character),
    .out_last      (out_if.last)
  );

endmodule

[hw/rtl/itrd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: accept, check alphabet, divide digit by digit, emit sign, emit.
// ----------------------------------------------------------------------------
module itrd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  itrd_pkg::itrd_stat_t stat,
  output itrd_pkg::itrd_cmd_t  cmd
);
  import itrd_pkg::*;

  itrd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = stat.ok ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (stat.div_done) state_nxt = stat.neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (stat.out_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free && stat.last_digit) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
      end
      ST_SIGN: begin
        cmd.sign = stat.out_free;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hw/rtl/itrd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_dp
// Datapath: configuration registers, 8-bit-per-cycle divider by the radix,
// digit stack and output register.
// ----------------------------------------------------------------------------
module itrd_dp #(
  parameter int MAX_RADIX = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [itrd_pkg::VALUE_W-1:0]     in_value,
  input  itrd_pkg::itrd_cmd_t                     cmd,
  output itrd_pkg::itrd_stat_t                    stat,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]             out_character,
  output logic                                    out_last
);
  import itrd_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RADIX);

  logic [LEN_W-1:0]      radix_length_r;
  logic [CFG_DATA_W-1:0] alphabet_low_r;
  logic [CFG_DATA_W-1:0] alphabet_high_r;
  itrd_alpha_t           alpha;

  logic                  ok_r;
  logic                  neg_r;
  logic [VALUE_W-1:0]    div_r;
  logic [DIGIT_W-1:0]    rem_r;
  logic [STEP_W-1:0]     step_r;
  logic [CNT_W-1:0]      nd_r;
  logic [DIGIT_W-1:0]    dig_r [MAX_DIGITS];

  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  logic [VALUE_W-1:0]       raw;
  logic [VALUE_W-1:0]       mag;
  logic                     len_ok;
  logic [BITS_PER_STEP-1:0] qbits;
  logic [DIGIT_W-1:0]       rem_step;
  logic [VALUE_W-1:0]       div_step;
  logic [CNT_W-1:0]         nd_dec;
  logic                     out_free;

  assign alpha  = {alphabet_high_r, alphabet_low_r};
  assign raw    = VALUE_W'(in_value);
  assign mag    = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
  assign len_ok = (radix_length_r >= LEN_W'(2)) && (radix_length_r <= MAX_LEN);
  assign nd_dec = nd_r - CNT_W'(1);

  // Eight restoring steps: shift one dividend bit into the remainder each.
  always_comb begin
    logic [LEN_W-1:0]   t;
    logic [DIGIT_W-1:0] r;
    r     = rem_r;
    qbits = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t = {r, div_r[VALUE_W-1-i]};
      if (t >= radix_length_r) begin
        t = t - radix_length_r;
        qbits[BITS_PER_STEP-1-i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_step = r;
  end

  assign div_step = {div_r[VALUE_W-BITS_PER_STEP-1:0], qbits};
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat            = '0;
    stat.ok         = ok_r;
    stat.neg        = neg_r;
    stat.div_done   = (step_r == LAST_STEP) && (div_step == '0);
    stat.out_free   = out_free;
    stat.last_digit = (nd_r == CNT_W'(1));
  end

  // Configuration and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_length_r  <= '0;
      alphabet_low_r  <= '0;
      alphabet_high_r <= '0;
      step_r          <= '0;
      nd_r            <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIX_LENGTH:  radix_length_r  <= cfg_data[LEN_W-1:0];
          CFG_ALPHABET_LOW:  alphabet_low_r  <= cfg_data;
          CFG_ALPHABET_HIGH: alphabet_high_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        step_r <= '0;
        nd_r   <= '0;
      end else if (cmd.step) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == LAST_STEP) nd_r <= nd_r + CNT_W'(1);
      end else if (cmd.emit) begin
        nd_r <= nd_dec;
      end
      if (cmd.sign || cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: value being divided, digit stack, output character.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_r <= mag;
      neg_r <= raw[VALUE_W-1];
      ok_r  <= len_ok && alphabet_chars_ok(radix_length_r, alpha);
      rem_r <= '0;
    end else if (cmd.step) begin
      div_r <= div_step;
      if (step_r == LAST_STEP) begin
        dig_r[nd_r[4:0]] <= rem_step;
        rem_r            <= '0;
      end else begin
        rem_r <= rem_step;
      end
    end
    if (cmd.sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit) begin
      out_char_r <= alpha[dig_r[nd_dec[4:0]]];
      out_last_r <= (nd_r == CNT_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

[hw/rtl/itrd_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_chk
// Port-level checks for the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module itrd_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [itrd_pkg::CHAR_W-1:0] out_character,
  input logic                        out_last
);
  import itrd_pkg::*;

  // Hold a stalled character.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output item changed");

  // Busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("input accepted again in the cycle after an accept");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The minus sign always has digits after it.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == CHAR_MINUS |-> !out_last)
    else $error("minus sign marked as last character");

endmodule

bind integer_to_radix_digits_unit itrd_chk u_itrd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_character (out_if.character),
  .out_last      (out_if.last)
);
